// File: hw/rtl/clkp_pkg.sv
// Package: shared types, keyword table and character codes for the keyword parser
`default_nettype none
package clkp_pkg;

   localparam int TOKEN_LIMIT = 16;
   localparam int LEN_WIDTH   = $clog2(TOKEN_LIMIT + 1);
   localparam int KW_COUNT    = 6;
   localparam int KW_MAX_LEN  = 5;

   typedef enum logic [2:0] {
      CMD_WAKE    = 3'd0,
      CMD_W       = 3'd1,
      CMD_SLEEP   = 3'd2,
      CMD_S       = 3'd3,
      CMD_RESET   = 3'd4,
      CMD_R       = 3'd5,
      CMD_INVALID = 3'd6
   } cmd_type;

   typedef logic [7:0]  char_type;
   typedef logic [31:0] value_type;

   localparam char_type CHAR_NUL   = 8'h00;
   localparam char_type CHAR_TAB   = 8'h09;
   localparam char_type CHAR_CR    = 8'h0D;
   localparam char_type CHAR_SPACE = 8'h20;
   localparam char_type CHAR_PLUS  = 8'h2B;
   localparam char_type CHAR_COMMA = 8'h2C;
   localparam char_type CHAR_MINUS = 8'h2D;
   localparam char_type CHAR_ZERO  = 8'h30;
   localparam char_type CHAR_NINE  = 8'h39;

   localparam char_type KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
      '{8'h77, 8'h61, 8'h6B, 8'h65, 8'h00},   // wake
      '{8'h77, 8'h00, 8'h00, 8'h00, 8'h00},   // w
      '{8'h73, 8'h6C, 8'h65, 8'h65, 8'h70},   // sleep
      '{8'h73, 8'h00, 8'h00, 8'h00, 8'h00},   // s
      '{8'h72, 8'h65, 8'h73, 8'h65, 8'h74},   // reset
      '{8'h72, 8'h00, 8'h00, 8'h00, 8'h00}    // r
   };

   localparam int KW_LEN [KW_COUNT] = '{4, 1, 5, 1, 5, 1};

endpackage
`default_nettype wire

// File: hw/rtl/clkp_if.sv
// Interfaces: valid/ready channels for received characters and parsed results
`default_nettype none
interface clkp_req_if
   import clkp_pkg::*;
   ;
   logic     valid;
   logic     ready;
   char_type character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

interface clkp_rsp_if
   import clkp_pkg::*;
   ;
   logic               valid;
   logic               ready;
   cmd_type            command;
   logic signed [31:0] argument;

   modport source (output valid, output command, output argument, input ready);
   modport sink   (input valid, input command, input argument, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/command_line_keyword_parser_unit.sv
// A carriage return is held in the input register, then its result in the result register.
// Throughput: one character per cycle; the input register and the result register
// part the two channels, so a new character is taken while a result waits.
// Only a carriage return meeting a full, untaken result register stalls the input.
// Reset (synchronous, active high): command mode, empty token, held command invalid,
// held argument zero, both channels empty.
`default_nettype none
module command_line_keyword_parser_unit
   import clkp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   clkp_req_if.sink   req_ch,
   clkp_rsp_if.source rsp_ch
);

   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   logic                 in_valid_ff, in_valid_in;
   char_type             in_char_ff, in_char_in;
   logic                 arg_mode_ff, arg_mode_in;
   logic [LEN_WIDTH-1:0] len_ff, len_in;
   logic [KW_COUNT-1:0]  alive_ff, alive_in;
   logic                 ended_ff, ended_in;
   phase_type            phase_ff, phase_in;
   logic                 neg_ff, neg_in;
   value_type            acc_ff, acc_in;
   cmd_type              held_cmd_ff, held_cmd_in;
   value_type            held_arg_ff, held_arg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   cmd_type              rsp_cmd_ff, rsp_cmd_in;
   value_type            rsp_arg_ff, rsp_arg_in;

   logic                 stage_go;
   logic                 is_cr;
   logic                 is_digit;
   logic                 is_blank;
   cmd_type              matched;
   value_type            digit_val;

   assign is_cr     = (in_char_ff == CHAR_CR);
   assign is_digit  = (in_char_ff >= CHAR_ZERO) && (in_char_ff <= CHAR_NINE);
   assign is_blank  = (in_char_ff == CHAR_SPACE) ||
                      ((in_char_ff >= CHAR_TAB) && (in_char_ff <= CHAR_CR));
   assign digit_val = {28'd0, in_char_ff[3:0]};
   assign stage_go  = in_valid_ff && !(is_cr && rsp_valid_ff && !rsp_ch.ready);

   assign req_ch.ready    = !in_valid_ff || stage_go;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.command  = rsp_cmd_ff;
   assign rsp_ch.argument = rsp_arg_ff;

   // first live keyword whose length is met, or a full buffer
   always_comb begin
      matched = CMD_INVALID;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (alive_ff[k] && (32'(len_ff) == KW_LEN[k] || 32'(len_ff) == TOKEN_LIMIT)) begin
            matched = cmd_type'(3'(k));
         end
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_char_in   = in_char_ff;
      arg_mode_in  = arg_mode_ff;
      len_in       = len_ff;
      alive_in     = alive_ff;
      ended_in     = ended_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      held_cmd_in  = held_cmd_ff;
      held_arg_in  = held_arg_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_arg_in   = rsp_arg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      if (stage_go) begin
         in_valid_in = 1'b0;
         if (in_char_ff == CHAR_COMMA) begin
            if (!arg_mode_ff) begin
               held_cmd_in = matched;
               arg_mode_in = 1'b1;
               len_in      = '0;
               alive_in    = '1;
               ended_in    = 1'b0;
               phase_in    = PH_SKIP;
               neg_in      = 1'b0;
               acc_in      = '0;
            end
         end else if (is_cr) begin
            if (arg_mode_ff) begin
               held_arg_in = neg_ff ? (32'd0 - acc_ff) : acc_ff;
            end else begin
               held_cmd_in = matched;
            end
            arg_mode_in  = 1'b0;
            len_in       = '0;
            alive_in     = '1;
            ended_in     = 1'b0;
            phase_in     = PH_SKIP;
            neg_in       = 1'b0;
            acc_in       = '0;
            rsp_cmd_in   = held_cmd_in;
            rsp_arg_in   = held_arg_in;
            rsp_valid_in = 1'b1;
         end else if (!ended_ff && (32'(len_ff) < TOKEN_LIMIT)) begin
            if (in_char_ff == CHAR_NUL) begin
               ended_in = 1'b1;
            end else begin
               for (int k = 0; k < KW_COUNT; k++) begin
                  if (32'(len_ff) >= KW_LEN[k]) begin
                     alive_in[k] = 1'b0;
                  end else if (KW_TEXT[k][3'(len_ff)] != in_char_ff) begin
                     alive_in[k] = 1'b0;
                  end
               end
               case (phase_ff)
                  PH_SKIP: begin
                     if (is_blank) begin
                        phase_in = PH_SKIP;
                     end else if (in_char_ff == CHAR_PLUS || in_char_ff == CHAR_MINUS) begin
                        neg_in   = (in_char_ff == CHAR_MINUS);
                        phase_in = PH_SIGN;
                     end else if (is_digit) begin
                        acc_in   = digit_val;
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
                  PH_SIGN, PH_DIGITS: begin
                     if (is_digit) begin
                        acc_in   = (acc_ff << 3) + (acc_ff << 1) + digit_val;
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
                  default: begin
                     phase_in = PH_DONE;
                  end
               endcase
               len_in = len_ff + LEN_WIDTH'(1);
            end
         end
      end

      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_ch.character;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         arg_mode_ff  <= 1'b0;
         len_ff       <= '0;
         alive_ff     <= '1;
         ended_ff     <= 1'b0;
         phase_ff     <= PH_SKIP;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         held_cmd_ff  <= CMD_INVALID;
         held_arg_ff  <= '0;
         rsp_cmd_ff   <= CMD_INVALID;
         rsp_arg_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         arg_mode_ff  <= arg_mode_in;
         len_ff       <= len_in;
         alive_ff     <= alive_in;
         ended_ff     <= ended_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         held_cmd_ff  <= held_cmd_in;
         held_arg_ff  <= held_arg_in;
         rsp_cmd_ff   <= rsp_cmd_in;
         rsp_arg_ff   <= rsp_arg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_char_ff <= in_char_in;
   end

endmodule
`default_nettype wire

// File: dv/clkp_line_checker.sv
// Checker: follows every transfer of the keyword parser, predicts each line result and compares
`timescale 1ns / 100ps
module clkp_line_checker
   import clkp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   clkp_req_if  req_mon,
   clkp_rsp_if  rsp_mon,
   output int   fail_count,
   output int   results_due
);

   typedef enum logic [1:0] {
      SKIP_BLANKS,
      AFTER_SIGN,
      IN_DIGITS,
      PARSE_DONE
   } parse_phase_type;

   typedef struct {
      cmd_type   command;
      value_type argument;
   } line_result_type;

   string keyword_text [6] = '{"wake", "w", "sleep", "s", "reset", "r"};

   bit              arg_mode;
   int              token_len;
   logic [5:0]      alive;
   bit              token_ended;
   parse_phase_type phase;
   bit              negative;
   value_type       acc;
   cmd_type         held_cmd;
   value_type       held_arg;

   line_result_type pending_replies [$];
   int              mismatches = 0;
   int              pending = 0;

   assign fail_count  = mismatches;
   assign results_due = pending;

   task automatic report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   function automatic void clear_token();
      token_len   = 0;
      alive       = '1;
      token_ended = 1'b0;
      phase       = SKIP_BLANKS;
      negative    = 1'b0;
      acc         = '0;
   endfunction

   function automatic cmd_type matched_keyword();
      for (int k = 0; k < 6; k++) begin
         if (alive[k] && (token_len == keyword_text[k].len() || token_len == TOKEN_LIMIT)) begin
            return cmd_type'(k);
         end
      end
      return CMD_INVALID;
   endfunction

   function automatic void take_token_char(char_type c);
      bit digit;
      bit blank;
      if (token_ended || token_len >= TOKEN_LIMIT) return;
      if (c == CHAR_NUL) begin
         token_ended = 1'b1;
         return;
      end
      for (int k = 0; k < 6; k++) begin
         if (token_len >= keyword_text[k].len() ||
             char_type'(keyword_text[k][token_len]) != c) begin
            alive[k] = 1'b0;
         end
      end
      digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
      blank = (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR));
      case (phase)
         SKIP_BLANKS: begin
            if (blank) begin
            end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               negative = (c == CHAR_MINUS);
               phase    = AFTER_SIGN;
            end else if (digit) begin
               acc   = value_type'(c - CHAR_ZERO);
               phase = IN_DIGITS;
            end else begin
               phase = PARSE_DONE;
            end
         end
         AFTER_SIGN, IN_DIGITS: begin
            if (digit) begin
               acc   = acc * 32'd10 + value_type'(c - CHAR_ZERO);
               phase = IN_DIGITS;
            end else begin
               phase = PARSE_DONE;
            end
         end
         default: ;
      endcase
      token_len++;
   endfunction

   function automatic void absorb_char(char_type c);
      line_result_type r;
      if (c == CHAR_COMMA) begin
         if (!arg_mode) begin
            held_cmd = matched_keyword();
            clear_token();
            arg_mode = 1'b1;
         end
      end else if (c == CHAR_CR) begin
         if (arg_mode) begin
            held_arg = negative ? -acc : acc;
         end else begin
            held_cmd = matched_keyword();
         end
         arg_mode = 1'b0;
         clear_token();
         r.command  = held_cmd;
         r.argument = held_arg;
         pending_replies.push_back(r);
      end else begin
         take_token_char(c);
      end
   endfunction

   always @(posedge clock) begin : watch
      line_result_type due;
      if (reset) begin
         arg_mode = 1'b0;
         clear_token();
         held_cmd = CMD_INVALID;
         held_arg = '0;
         pending_replies.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) absorb_char(req_mon.character);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_replies.size() == 0) begin
               report($sformatf("result transfer with none due: command %0d argument %0d",
                                rsp_mon.command, rsp_mon.argument));
            end else begin
               due = pending_replies.pop_front();
               if (rsp_mon.command !== due.command)
                  report($sformatf("command %0d, expected %0d", rsp_mon.command, due.command));
               if (rsp_mon.argument !== due.argument)
                  report($sformatf("argument %0d, expected %0d",
                                   rsp_mon.argument, $signed(due.argument)));
            end
         end
      end
      pending = pending_replies.size();
   end

endmodule

// File: dv/command_line_keyword_parser_unit_tb.sv
// Testbench top: clock, reset, character stimulus, result back-pressure and verdict
`timescale 1ns / 100ps
module command_line_keyword_parser_unit_tb
   import clkp_pkg::*;
;

   localparam int CHARS_WANTED = 1200;
   localparam int STALL_LIMIT  = 400;
   localparam int DRAIN_CYCLES = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   clkp_req_if req_ch ();
   clkp_rsp_if rsp_ch ();

   int fail_count;
   int results_due;
   int idle_cycles = 0;
   int chars_sent = 0;
   bit steady = 1'b0;

   string    keyword_text [6] = '{"wake", "w", "sleep", "s", "reset", "r"};
   char_type line_buf [$];

   command_line_keyword_parser_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   clkp_line_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("** command_line_keyword_parser_unit: FAILED **");
         $finish;
      end
   end

   // result side back-pressure
   initial begin : rsp_sink
      int stall;
      rsp_ch.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
      end
   end

   function automatic void add_text(string s);
      foreach (s[i]) line_buf.push_back(char_type'(s[i]));
   endfunction

   function automatic char_type random_char();
      string t;
      if ($urandom_range(0, 1)) return char_type'($urandom_range(0, 255));
      t = keyword_text[$urandom_range(0, 5)];
      return char_type'(t[$urandom_range(0, t.len() - 1)]);
   endfunction

   function automatic char_type random_digit();
      return char_type'(CHAR_ZERO + $urandom_range(0, 9));
   endfunction

   task automatic send_char(char_type c);
      int stall;
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
         req_ch.valid <= 1'b0;
         repeat (stall) @(negedge clock);
      end
      req_ch.character <= c;
      req_ch.valid     <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_line();
      line_buf.push_back(CHAR_CR);
      foreach (line_buf[i]) send_char(line_buf[i]);
      line_buf.delete();
   endtask

   initial begin : stimulus
      int kw;
      req_ch.valid     = 1'b0;
      req_ch.character = CHAR_NUL;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: empty line, zero byte, comma in argument, non-numeric, long wrapping argument
      send_line();
      add_text("w");
      line_buf.push_back(CHAR_NUL);
      add_text("q,,-5");
      send_line();
      add_text("s,");
      line_buf.push_back(8'hFF);
      send_line();
      add_text("wake");
      send_line();
      add_text("sleep");
      send_line();
      add_text("reset,");
      line_buf.push_back(CHAR_TAB);
      add_text(" 7");
      send_line();
      add_text("r,99999999999999999");
      send_line();

      while (chars_sent < CHARS_WANTED) begin
         steady = ($urandom_range(0, 4) == 0);
         kw = $urandom_range(0, 5);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: add_text(keyword_text[kw]);
            6: add_text(keyword_text[kw].substr(0, $urandom_range(0, keyword_text[kw].len() - 1)));
            7: begin
               add_text(keyword_text[kw]);
               line_buf.push_back(random_char());
            end
            default: repeat ($urandom_range(0, 20)) line_buf.push_back(random_char());
         endcase
         if ($urandom_range(0, 9) == 0) line_buf.push_back(char_type'($urandom_range(0, 255)));
         if ($urandom_range(0, 3) != 0) begin
            line_buf.push_back(CHAR_COMMA);
            repeat ($urandom_range(0, 2))
               line_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE :
                                  char_type'($urandom_range(CHAR_TAB, CHAR_CR - 1)));
            case ($urandom_range(0, 3))
               1: line_buf.push_back(CHAR_PLUS);
               2: line_buf.push_back(CHAR_MINUS);
               default: ;
            endcase
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(11, 20) : $urandom_range(0, 10))
               line_buf.push_back(random_digit());
            if ($urandom_range(0, 5) == 0) begin
               line_buf.push_back(char_type'($urandom_range(0, 255)));
               repeat ($urandom_range(0, 3)) line_buf.push_back(random_digit());
            end
         end
         send_line();
      end
      req_ch.valid <= 1'b0;
      steady = 1'b0;

      while (results_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && results_due == 0) begin
         $display("** command_line_keyword_parser_unit: PASSED **");
      end else begin
         $display("** command_line_keyword_parser_unit: FAILED **");
      end
      $finish;
   end

endmodule
